// ----- hdl/jrdc_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the journal record deframer.
// No dependencies; the parser, the result buffer, the top level and the testbench import this package.
`timescale 1ns / 1ps

package jrdc_pkg;

    localparam int unsigned HEADER_BYTES = 13;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [31:0] MAGIC_RESET  = 32'h434D_4A4F;
    localparam logic [7:0]  TYPE_MIN     = 8'h01;
    localparam logic [7:0]  TYPE_MAX     = 8'h04;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CORRUPT = 3'd1;
    localparam logic [2:0] ST_CRC     = 3'd2;
    localparam logic [2:0] ST_TYPE    = 3'd3;
    localparam logic [2:0] ST_END     = 3'd4;

    // Header byte positions
    localparam logic [3:0] HC_LENGTH = 4'd4;
    localparam logic [3:0] HC_CRC    = 4'd8;
    localparam logic [3:0] HC_TYPE   = 4'd12;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  record_type;
        logic [31:0] record_length;
        logic        journal_end;
    } t_result;

    // Reflected CRC-32 update over one byte, one shift per bit
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hdl/jrdc_in_if.sv -----
// Byte input channel of the journal record deframer.
// Depends on nothing; carries valid, ready and one journal byte with its final flag.
`timescale 1ns / 1ps

interface jrdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] journal_byte;
    logic       final_byte;

    modport source (output valid, output journal_byte, output final_byte, input ready);
    modport sink   (input valid, input journal_byte, input final_byte, output ready);
endinterface

// ----- hdl/jrdc_out_if.sv -----
// Result channel of the journal record deframer.
// Depends on nothing; carries valid, ready and one record report.
`timescale 1ns / 1ps

interface jrdc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  record_type;
    logic [31:0] record_length;
    logic        journal_end;

    modport source (output valid, output status, output record_type,
                    output record_length, output journal_end, input ready);
    modport sink   (input valid, input status, input record_type,
                    input record_length, input journal_end, output ready);
endinterface

// ----- hdl/jrdc_cfg_if.sv -----
// Configuration write channel of the journal record deframer.
// Depends on nothing; carries valid, ready and the record magic word.
`timescale 1ns / 1ps

interface jrdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] record_magic;

    modport source (output valid, output record_magic, input ready);
    modport sink   (input valid, input record_magic, output ready);
endinterface

// ----- hdl/jrdc_parse.sv -----
// Record parser: header gathering, payload CRC, length count and status decision.
// Depends on jrdc_pkg and jrdc_in_if; produces at most one result per accepted beat.
`timescale 1ns / 1ps

module jrdc_parse
    import jrdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    jrdc_in_if.sink     i_in,
    input  logic        i_space,
    input  logic [31:0] i_record_magic,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [3:0]  r_header_count, n_header_count;
    logic [31:0] r_magic_gather, n_magic_gather;
    logic [31:0] r_length_gather, n_length_gather;
    logic [31:0] r_expected_crc, n_expected_crc;
    logic [7:0]  r_type_held, n_type_held;
    logic [31:0] r_payload_left, n_payload_left;
    logic [31:0] r_running_crc, n_running_crc;
    logic        r_in_payload, n_in_payload;
    logic        r_dropping, n_dropping;

    logic        acc;
    logic [7:0]  b;
    logic        fin;
    logic [31:0] crc_next;
    logic [31:0] left_next;
    logic        magic_ok;
    logic        clear;
    logic [2:0]  fin_status;

    assign i_in.ready = i_space;
    assign acc = i_in.valid && i_space;
    assign b   = i_in.journal_byte;
    assign fin = i_in.final_byte;

    assign crc_next  = crc_byte(r_running_crc, b);
    assign left_next = r_payload_left - 32'd1;
    assign magic_ok  = (r_magic_gather == i_record_magic);

    // Decide the record status at its end
    always_comb begin
        logic [31:0] crc_sel;
        logic [7:0]  type_sel;
        crc_sel  = r_in_payload ? crc_next : r_running_crc;
        type_sel = r_in_payload ? r_type_held : b;
        if ((crc_sel ^ ALL_ONES) != r_expected_crc) begin
            fin_status = ST_CRC;
        end else if (type_sel < TYPE_MIN || type_sel > TYPE_MAX) begin
            fin_status = ST_TYPE;
        end else begin
            fin_status = ST_OK;
        end
    end

    // Advance the record state for one beat
    always_comb begin
        n_header_count  = r_header_count;
        n_magic_gather  = r_magic_gather;
        n_length_gather = r_length_gather;
        n_expected_crc  = r_expected_crc;
        n_type_held     = r_type_held;
        n_payload_left  = r_payload_left;
        n_running_crc   = r_running_crc;
        n_in_payload    = r_in_payload;
        n_dropping      = r_dropping;
        clear           = 1'b0;
        o_res_valid     = 1'b0;
        o_res           = '{status: ST_OK, record_type: r_type_held,
                            record_length: r_length_gather, journal_end: fin};

        if (acc) begin
            if (r_dropping) begin
                // Drop everything up to the final byte
                if (fin) begin
                    clear      = 1'b1;
                    n_dropping = 1'b0;
                end
            end else if (!r_in_payload) begin
                n_header_count = r_header_count + 4'd1;
                if (r_header_count < HC_LENGTH) begin
                    n_magic_gather[8*r_header_count[1:0] +: 8] = b;
                end else if (r_header_count < HC_CRC) begin
                    n_length_gather[8*r_header_count[1:0] +: 8] = b;
                end else if (r_header_count < HC_TYPE) begin
                    n_expected_crc[8*r_header_count[1:0] +: 8] = b;
                end else begin
                    n_type_held = b;
                end

                if (r_header_count != HC_TYPE) begin
                    // Short tail: ignore the partial header
                    if (fin) begin
                        o_res_valid = 1'b1;
                        o_res = '{status: ST_END, record_type: 8'd0,
                                  record_length: 32'd0, journal_end: 1'b1};
                        clear = 1'b1;
                    end
                end else if (!magic_ok) begin
                    o_res_valid = 1'b1;
                    o_res = '{status: ST_CORRUPT, record_type: b,
                              record_length: r_length_gather, journal_end: 1'b1};
                    clear      = 1'b1;
                    n_dropping = !fin;
                end else if (r_length_gather == 32'd0) begin
                    o_res_valid = 1'b1;
                    o_res = '{status: fin_status, record_type: b,
                              record_length: r_length_gather,
                              journal_end: fin || (fin_status != ST_OK)};
                    clear      = 1'b1;
                    n_dropping = !fin && (fin_status != ST_OK);
                end else begin
                    n_in_payload   = 1'b1;
                    n_payload_left = r_length_gather;
                    if (fin) begin
                        o_res_valid = 1'b1;
                        o_res = '{status: ST_CORRUPT, record_type: b,
                                  record_length: r_length_gather, journal_end: 1'b1};
                        clear = 1'b1;
                    end
                end
            end else begin
                // Payload byte: run the CRC and count down
                n_running_crc  = crc_next;
                n_payload_left = left_next;
                if (left_next == 32'd0) begin
                    o_res_valid = 1'b1;
                    o_res = '{status: fin_status, record_type: r_type_held,
                              record_length: r_length_gather,
                              journal_end: fin || (fin_status != ST_OK)};
                    clear      = 1'b1;
                    n_dropping = !fin && (fin_status != ST_OK);
                end else if (fin) begin
                    o_res_valid = 1'b1;
                    o_res = '{status: ST_CORRUPT, record_type: r_type_held,
                              record_length: r_length_gather, journal_end: 1'b1};
                    clear = 1'b1;
                end
            end

            if (clear) begin
                n_header_count  = 4'd0;
                n_magic_gather  = 32'd0;
                n_length_gather = 32'd0;
                n_expected_crc  = 32'd0;
                n_type_held     = 8'd0;
                n_payload_left  = 32'd0;
                n_running_crc   = ALL_ONES;
                n_in_payload    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count  <= 4'd0;
            r_magic_gather  <= 32'd0;
            r_length_gather <= 32'd0;
            r_expected_crc  <= 32'd0;
            r_type_held     <= 8'd0;
            r_payload_left  <= 32'd0;
            r_running_crc   <= ALL_ONES;
            r_in_payload    <= 1'b0;
            r_dropping      <= 1'b0;
        end else begin
            r_header_count  <= n_header_count;
            r_magic_gather  <= n_magic_gather;
            r_length_gather <= n_length_gather;
            r_expected_crc  <= n_expected_crc;
            r_type_held     <= n_type_held;
            r_payload_left  <= n_payload_left;
            r_running_crc   <= n_running_crc;
            r_in_payload    <= n_in_payload;
            r_dropping      <= n_dropping;
        end
    end

endmodule

// ----- hdl/jrdc_out_buf.sv -----
// Two-entry result buffer between the parser and the result channel.
// Depends on jrdc_pkg and jrdc_out_if; head entry drives the channel.
`timescale 1ns / 1ps

module jrdc_out_buf
    import jrdc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_res,
    output logic       o_space,
    jrdc_out_if.source o_out
);

    logic [1:0] r_count, n_count;
    t_result    r_head;
    t_result    r_tail;
    logic       pop;

    assign pop     = o_out.valid && o_out.ready;
    assign o_space = (r_count != 2'd2);

    assign o_out.valid         = (r_count != 2'd0);
    assign o_out.status        = r_head.status;
    assign o_out.record_type   = r_head.record_type;
    assign o_out.record_length = r_head.record_length;
    assign o_out.journal_end   = r_head.journal_end;

    assign n_count = r_count + {1'b0, i_push} - {1'b0, pop};

    // Hold the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // Shift the tail forward on a pop; fill the first free entry on a push
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_head <= (r_count == 2'd2) ? r_tail : i_res;
            r_tail <= i_res;
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_head <= i_res;
            end else begin
                r_tail <= i_res;
            end
        end
    end

endmodule

// ----- hdl/journal_record_deframer_crc32.sv -----
// Journal record deframer with CRC-32 check: takes one journal byte per beat and
// reports one result per record (status, type, length, journal end). Each byte is
// handled in the cycle it is accepted, so the block sustains one byte per clock;
// a two-entry result buffer lets bytes keep flowing while a result waits, and
// input ready falls only when two results are waiting. Write the magic register
// only while idle; it resets to 0x434D4A4F and the config channel is always ready.
`timescale 1ns / 1ps

module journal_record_deframer_crc32
    import jrdc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    jrdc_in_if.sink    i_in,
    jrdc_cfg_if.sink   i_cfg,
    jrdc_out_if.source o_out
);

    logic [31:0] r_record_magic;
    logic        res_valid;
    t_result     res;
    logic        space;

    // Take configuration writes at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_magic <= MAGIC_RESET;
        end else if (i_cfg.valid) begin
            r_record_magic <= i_cfg.record_magic;
        end
    end

    jrdc_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_space        (space),
        .i_record_magic (r_record_magic),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    jrdc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_space (space),
        .o_out   (o_out)
    );

    // Every error report closes the journal
    a_error_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && (res.status == ST_CORRUPT || res.status == ST_CRC ||
                      res.status == ST_TYPE) |-> res.journal_end)
        else $error("error result without journal end");

    // A journal-end report carries no record
    a_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res.status == ST_END |->
            res.record_type == 8'd0 && res.record_length == 32'd0 && res.journal_end)
        else $error("journal-end result carries record fields");

    // No result is produced without an accepted beat
    a_res_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> i_in.valid && i_in.ready)
        else $error("result without accepted byte");

    // The result channel is empty at the first edge out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out.valid)
        else $error("result valid after reset");

endmodule

// ----- verif/tb_journal_record_deframer_crc32.sv -----
// Self-checking testbench for the journal record deframer with CRC-32 check.
// Depends on jrdc_pkg, the three channel interfaces and the deframer top level;
// a built-in predictor tracks the header, payload CRC and drop state per byte.
`timescale 1ns / 1ps

module tb_journal_record_deframer_crc32;
    import jrdc_pkg::*;

    // One directed journal fragment: a record header, a short payload, then
    // truncation or padding to a fixed byte count
    typedef struct packed {
        logic [31:0] magic;
        logic [31:0] len;
        logic [31:0] crc;
        logic [7:0]  typ;
        logic [7:0]  body;
        logic [7:0]  total;
        logic        last;
        logic        fix_crc;
        logic [7:0]  seed;
        logic        typed;
        t_result     want;
    } t_row;

    localparam t_row DIRECTED [12] = '{
        // short tail: one byte, then the journal ends
        '{MAGIC_RESET, 32'h0, 32'h0, 8'h01, 8'd0, 8'd1, 1'b1, 1'b0, 8'h00, 1'b1,
          '{ST_END, 8'h00, 32'h0, 1'b1}},
        // empty payload, good record, journal carries on
        '{MAGIC_RESET, 32'h0, 32'h0, 8'h01, 8'd0, 8'd13, 1'b0, 1'b0, 8'h00, 1'b1,
          '{ST_OK, 8'h01, 32'h0, 1'b0}},
        '{MAGIC_RESET, 32'd3, 32'h0, 8'h04, 8'd3, 8'd16, 1'b0, 1'b1, 8'hFF, 1'b0,
          '{ST_OK, 8'h00, 32'h0, 1'b0}},
        // good record completed on the final byte
        '{MAGIC_RESET, 32'd2, 32'h0, 8'h02, 8'd2, 8'd15, 1'b1, 1'b1, 8'h00, 1'b0,
          '{ST_OK, 8'h00, 32'h0, 1'b0}},
        '{MAGIC_RESET, 32'h0, 32'h0, 8'h03, 8'd0, 8'd13, 1'b0, 1'b0, 8'h00, 1'b1,
          '{ST_OK, 8'h03, 32'h0, 1'b0}},
        // twelve header bytes, then the journal ends
        '{MAGIC_RESET, 32'h0, 32'h0, 8'h01, 8'd0, 8'd12, 1'b1, 1'b0, 8'h00, 1'b1,
          '{ST_END, 8'h00, 32'h0, 1'b1}},
        // wrong magic, following bytes dropped up to the final one
        '{32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 8'h80, 8'd0, 8'd15, 1'b1, 1'b0, 8'hA5,
          1'b1, '{ST_CORRUPT, 8'h80, 32'h1234_5678, 1'b1}},
        // checksum mismatch, then a dropped final byte
        '{MAGIC_RESET, 32'd1, 32'hDEAD_BEEF, 8'h01, 8'd1, 8'd15, 1'b1, 1'b0, 8'h5A,
          1'b0, '{ST_OK, 8'h00, 32'h0, 1'b0}},
        // type below range
        '{MAGIC_RESET, 32'h0, 32'h0, 8'h00, 8'd0, 8'd14, 1'b1, 1'b0, 8'h00, 1'b1,
          '{ST_TYPE, 8'h00, 32'h0, 1'b1}},
        // type above range, record done on the final byte
        '{MAGIC_RESET, 32'd1, 32'h0, 8'hFF, 8'd1, 8'd14, 1'b1, 1'b1, 8'h80, 1'b0,
          '{ST_OK, 8'h00, 32'h0, 1'b0}},
        // journal ends inside the longest possible payload
        '{MAGIC_RESET, 32'hFFFF_FFFF, 32'h0, 8'h02, 8'd2, 8'd15, 1'b1, 1'b0, 8'h11,
          1'b1, '{ST_CORRUPT, 8'h02, 32'hFFFF_FFFF, 1'b1}},
        // journal ends right on the last header byte
        '{MAGIC_RESET, 32'd5, 32'h0, 8'h04, 8'd0, 8'd13, 1'b1, 1'b0, 8'h00, 1'b1,
          '{ST_CORRUPT, 8'h04, 32'd5, 1'b1}}
    };

    logic i_clk;
    logic i_rst_n;

    jrdc_in_if  in_bus ();
    jrdc_cfg_if cfg_bus ();
    jrdc_out_if res_bus ();

    journal_record_deframer_crc32 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (res_bus)
    );

    // Predictor state
    logic [31:0] magic_reg;
    logic [3:0]  hdr_pos;
    logic [31:0] magic_acc;
    logic [31:0] len_acc;
    logic [31:0] crc_want;
    logic [7:0]  type_acc;
    logic [31:0] bytes_left;
    logic [31:0] crc_run;
    logic        in_body;
    logic        skipping;

    t_result     pending_reports [$];
    logic [8:0]  stream_q [$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          phase_items  = 0;
    bit          steady_in    = 1'b0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Stop a hung run
    initial begin : watchdog
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'h0, b};
        repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        return c;
    endfunction

    function automatic void restart_record();
        hdr_pos    = '0;
        magic_acc  = '0;
        len_acc    = '0;
        crc_want   = '0;
        type_acc   = '0;
        bytes_left = '0;
        crc_run    = ALL_ONES;
        in_body    = 1'b0;
    endfunction

    // Error report: always the last of the journal; drop bytes unless already final
    function automatic t_result fail_record(input logic [2:0] st, input logic fin);
        t_result rep;
        rep.status        = st;
        rep.record_type   = type_acc;
        rep.record_length = len_acc;
        rep.journal_end   = 1'b1;
        restart_record();
        skipping = !fin;
        return rep;
    endfunction

    function automatic t_result settle_record(input logic fin);
        t_result rep;
        if ((crc_run ^ ALL_ONES) != crc_want) return fail_record(ST_CRC, fin);
        if (type_acc < TYPE_MIN || type_acc > TYPE_MAX) return fail_record(ST_TYPE, fin);
        rep.status        = ST_OK;
        rep.record_type   = type_acc;
        rep.record_length = len_acc;
        rep.journal_end   = fin;
        restart_record();
        return rep;
    endfunction

    // Advance the deframer by one byte; return 1 when a report is due
    function automatic bit deframe_byte(input logic [7:0] b, input logic fin,
                                        output t_result rep);
        int pos;
        rep = '0;
        pos = int'(hdr_pos);
        if (skipping) begin
            if (fin) begin
                restart_record();
                skipping = 1'b0;
            end
            return 1'b0;
        end
        if (!in_body) begin
            if (pos < 4) magic_acc[8*pos +: 8] = b;
            else if (pos < 8) len_acc[8*(pos-4) +: 8] = b;
            else if (pos < 12) crc_want[8*(pos-8) +: 8] = b;
            else type_acc = b;
            hdr_pos = hdr_pos + 4'd1;
            if (hdr_pos < HEADER_BYTES) begin
                if (!fin) return 1'b0;
                rep.status      = ST_END;
                rep.journal_end = 1'b1;
                restart_record();
                return 1'b1;
            end
            if (magic_acc != magic_reg) begin
                rep = fail_record(ST_CORRUPT, fin);
                return 1'b1;
            end
            if (len_acc == 0) begin
                rep = settle_record(fin);
                return 1'b1;
            end
            in_body    = 1'b1;
            bytes_left = len_acc;
            if (!fin) return 1'b0;
            rep = fail_record(ST_CORRUPT, fin);
            return 1'b1;
        end
        crc_run    = crc32_step(crc_run, b);
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 0) begin
            rep = settle_record(fin);
            return 1'b1;
        end
        if (!fin) return 1'b0;
        rep = fail_record(ST_CORRUPT, fin);
        return 1'b1;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), {1'b0, b});
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) put_byte(w[8*k +: 8]);
    endfunction

    function automatic void mark_final();
        stream_q[stream_q.size() - 1][8] = 1'b1;
    endfunction

    function automatic void put_record(input logic [31:0] magic, input logic [31:0] len,
                                       input bit fix_crc, input logic [31:0] crc_v,
                                       input logic [7:0] typ, input logic [7:0] body [$]);
        logic [31:0] c;
        c = ALL_ONES;
        foreach (body[i]) c = crc32_step(c, body[i]);
        put_word(magic);
        put_word(len);
        put_word(fix_crc ? (c ^ ALL_ONES) : crc_v);
        put_byte(typ);
        foreach (body[i]) put_byte(body[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        mismatches++;
        $display("mismatch in %s: got %h, want %h at %0t", what, got_v, want_v, $time);
    endtask

    task automatic compare_report(input t_result got);
        t_result want;
        results_seen++;
        if (pending_reports.size() == 0) begin
            report_mismatch("unexpected result, status", 32'(got.status), '0);
            return;
        end
        want = pending_reports.pop_front();
        if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.record_type != want.record_type)
            report_mismatch("record_type", 32'(got.record_type), 32'(want.record_type));
        if (got.record_length != want.record_length)
            report_mismatch("record_length", got.record_length, want.record_length);
        if (got.journal_end != want.journal_end)
            report_mismatch("journal_end", 32'(got.journal_end), 32'(want.journal_end));
    endtask

    // Offer one beat at the falling edge; hold it until taken at a rising edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (steady_in || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.journal_byte <= b;
        in_bus.final_byte   <= fin;
        do @(posedge i_clk); while (!in_bus.ready);
        phase_items++;
    endtask

    task automatic play_bytes(input bit typed, input t_result typed_rep);
        t_result rep;
        foreach (stream_q[i]) begin
            send_byte(stream_q[i][7:0], stream_q[i][8]);
            if (deframe_byte(stream_q[i][7:0], stream_q[i][8], rep))
                pending_reports.insert(pending_reports.size(), typed ? typed_rep : rep);
        end
        stream_q.delete();
    endtask

    task automatic play_row(input t_row rw);
        logic [7:0] body [$];
        for (int k = 0; k < rw.body; k++) body.insert(body.size(), rw.seed ^ 8'(k * 59));
        put_record(rw.magic, rw.len, rw.fix_crc, rw.crc, rw.typ, body);
        while (stream_q.size() > rw.total) void'(stream_q.pop_back());
        while (stream_q.size() < rw.total) put_byte(rw.seed ^ 8'(stream_q.size()));
        if (rw.last) mark_final();
        play_bytes(rw.typed, rw.want);
    endtask

    // Mostly well-formed records with random content; some broken, some noise
    task automatic random_journal();
        logic [7:0]  body [$];
        logic [31:0] len;
        logic [31:0] mg;
        logic [7:0]  typ;
        bit          huge;
        int          nrec;
        int          n;
        int          ending;
        steady_in = ($urandom_range(0, 4) == 0);
        huge = 1'b0;
        if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(1, 30);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
            mark_final();
            play_bytes(1'b0, '0);
            return;
        end
        nrec = $urandom_range(1, 4);
        for (int r = 0; r < nrec && !huge; r++) begin
            body.delete();
            n  = $urandom_range(0, 99);
            mg = ($urandom_range(0, 19) == 0) ? $urandom : magic_reg;
            if (n < 10) len = 0;
            else if (n < 85) len = $urandom_range(1, 8);
            else if (n < 97) len = $urandom_range(9, 40);
            else begin
                len  = $urandom | 32'h0000_1000;
                huge = 1'b1;
            end
            typ = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(TYPE_MIN, TYPE_MAX))
                                               : 8'($urandom_range(0, 255));
            n = huge ? $urandom_range(0, 6) : len;
            repeat (n) body.insert(body.size(), 8'($urandom_range(0, 255)));
            put_record(mg, len, $urandom_range(0, 99) < 88, $urandom, typ, body);
        end
        ending = $urandom_range(0, 99);
        if (!huge && ending >= 55 && ending < 80) begin
            n = $urandom_range(1, 12);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end else if (!huge && ending >= 80) begin
            n = $urandom_range(1, stream_q.size());
            while (stream_q.size() > n) void'(stream_q.pop_back());
        end
        mark_final();
        play_bytes(1'b0, '0);
    endtask

    // Pause the sender until every report is in, then let the block go quiet
    task automatic drain_reports();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_magic(input logic [31:0] v);
        @(negedge i_clk);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.record_magic <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        magic_reg = v;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Result sink: sample at the rising edge, compare at the next falling edge
    initial begin : result_sink
        t_result got;
        bit      held;
        bit      steady_out;
        int      hold_left;
        int      hold_marks;
        int      stall_left;
        int      cycle;
        held       = 1'b0;
        steady_out = 1'b0;
        hold_left  = 0;
        hold_marks = 0;
        stall_left = 0;
        cycle      = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (held) compare_report(got);
            held = 1'b0;
            cycle++;
            if (cycle % 64 == 0) steady_out = ($urandom_range(0, 3) == 0);
            // Long hold-off twice, so that the block backs up and stalls its input
            if (hold_left == 0 && hold_marks < 2
                    && results_seen >= (hold_marks == 0 ? 20 : 60)) begin
                hold_left = 150;
                hold_marks++;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
                if (!steady_out && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
            @(posedge i_clk);
            if (i_rst_n && res_bus.valid && res_bus.ready) begin
                got.status        = res_bus.status;
                got.record_type   = res_bus.record_type;
                got.record_length = res_bus.record_length;
                got.journal_end   = res_bus.journal_end;
                held = 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] phase_magic;
        i_rst_n              = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.journal_byte  = 8'h00;
        in_bus.final_byte    = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.record_magic = 32'h0;
        magic_reg            = MAGIC_RESET;
        skipping             = 1'b0;
        restart_record();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) play_row(DIRECTED[i]);

        // Random phases, each under its own magic word
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       phase_magic = 32'h0000_0000;
                1:       phase_magic = 32'hFFFF_FFFF;
                2:       phase_magic = $urandom;
                default: phase_magic = MAGIC_RESET;
            endcase
            drain_reports();
            write_magic(phase_magic);
            phase_items = 0;
            while (phase_items < 150) random_journal();
        end

        drain_reports();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
